// ----- design/nsst_pkg.sv -----
// Package for the top-N sorted score table.
// Holds widths, command codes and the control beat shared by the top level and cells.
// No dependencies.
`timescale 1ns / 1ps

package nsst_pkg;

    localparam int SCORE_W        = 16;
    localparam int RANK_W         = 4;
    localparam int CMD_W          = 2;
    localparam int TABLE_SIZE_DEF = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                shift_en;  // a qualifying insert this cycle
        logic                clear;     // empty the table
        logic [SCORE_W-1:0]  score;     // value being inserted
    } cell_ctrl_t;

endpackage

// ----- design/nsst_cell.sv -----
// One slot of the sorted score table.
// Holds one entry and compares it against the broadcast score; depends on nsst_pkg.
`timescale 1ns / 1ps

module nsst_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nsst_pkg::cell_ctrl_t          ctrl,
    input  logic [nsst_pkg::SCORE_W-1:0]  prev_value,
    input  logic                          prev_gt,
    output logic [nsst_pkg::SCORE_W-1:0]  value,
    output logic                          gt
);

    logic [nsst_pkg::SCORE_W-1:0] value_reg;
    logic [nsst_pkg::SCORE_W-1:0] value_next;

    // Empty slots hold zero and scores that enter are nonzero, so no fill mask is needed.
    assign gt    = (value_reg > ctrl.score);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
        end
        else if (ctrl.shift_en && !gt)
        begin
            // Take the new score at the boundary, otherwise shift down from the neighbor.
            value_next = prev_gt ? ctrl.score : prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ----- design/top_n_sorted_score_table.sv -----
// Top level of the top-N sorted score table.
// Builds a chain of nsst_cell slots and registers one result per command; uses nsst_pkg.
`timescale 1ns / 1ps

// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+---------------------------------
// command  | start, busy, command, score, rank       | beat taken when start & !busy
// result   | done, placed_rank, qualifies,           | one-cycle strobe on done,
//          | entry_value                             | no backpressure
//
// Commands never stall: the table is a row of TABLE_SIZE cells that each
// compare their entry with the score in parallel and shift toward the tail in the
// same edge, so busy stays low and a new beat may follow every cycle.
// The result appears on the cycle after the beat is taken and holds until the next beat.
// Reset clears every cell to zero (empty table) and drops done.
// The fill count is implied by the cells: a slot is filled exactly when it is nonzero.

module top_n_sorted_score_table
#(
    parameter int TABLE_SIZE = nsst_pkg::TABLE_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [nsst_pkg::CMD_W-1:0]    command,
    input  logic [nsst_pkg::SCORE_W-1:0]  score,
    input  logic [nsst_pkg::RANK_W-1:0]   rank,
    output logic                          done,
    output logic [nsst_pkg::RANK_W-1:0]   placed_rank,
    output logic                          qualifies,
    output logic [nsst_pkg::SCORE_W-1:0]  entry_value
);

    localparam int POS_W = $clog2(TABLE_SIZE + 1);
    localparam int SUM_W = POS_W + nsst_pkg::RANK_W;

    nsst_pkg::cmd_t        cmd;
    nsst_pkg::cell_ctrl_t  ctrl;

    logic [nsst_pkg::SCORE_W-1:0] cell_value [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]        cell_gt;

    logic                          accept;
    logic                          qual;
    logic [POS_W-1:0]              pos;
    logic [SUM_W-1:0]              rank_sum;
    logic [nsst_pkg::SCORE_W-1:0]  read_value;

    logic                          done_reg;
    logic [nsst_pkg::RANK_W-1:0]   placed_rank_reg;
    logic                          qualifies_reg;
    logic [nsst_pkg::SCORE_W-1:0]  entry_value_reg;

    logic [nsst_pkg::RANK_W-1:0]   placed_rank_next;
    logic                          qualifies_next;
    logic [nsst_pkg::SCORE_W-1:0]  entry_value_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cmd    = nsst_pkg::cmd_t'(command);

    // A nonzero score enters when it beats the tail; an empty tail reads as zero.
    assign qual = (score != '0) && (score > cell_value[TABLE_SIZE-1]);

    assign ctrl.shift_en = accept && (cmd == nsst_pkg::CMD_INSERT) && qual;
    assign ctrl.clear    = accept && (cmd == nsst_pkg::CMD_CLEAR);
    assign ctrl.score    = score;

    // Advance data down the chain: each cell sees its upstream neighbor.
    generate
        for (genvar i = 0; i < TABLE_SIZE; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                nsst_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .prev_value (score),
                    .prev_gt    (1'b1),
                    .value      (cell_value[i]),
                    .gt         (cell_gt[i])
                );
            end
            else
            begin : g_body
                nsst_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .prev_value (cell_value[i-1]),
                    .prev_gt    (cell_gt[i-1]),
                    .value      (cell_value[i]),
                    .gt         (cell_gt[i])
                );
            end
        end
    endgenerate

    // Encode the insert position: the one cell where the greater-than prefix ends.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (((i == 0) || cell_gt[(i == 0) ? 0 : i-1]) && !cell_gt[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
    end

    assign rank_sum = SUM_W'(pos) + SUM_W'(1);

    // Select the entry for a read; rank zero or beyond the table matches no cell.
    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (32'(rank) == (i + 1))
            begin
                read_value = cell_value[i];
            end
        end
    end

    always_comb
    begin
        placed_rank_next = '0;
        qualifies_next   = 1'b0;
        entry_value_next = '0;
        unique case (cmd)
            nsst_pkg::CMD_INSERT:
            begin
                qualifies_next = qual;
                if (qual)
                begin
                    placed_rank_next = rank_sum[nsst_pkg::RANK_W-1:0];
                end
            end
            nsst_pkg::CMD_CHECK:
            begin
                qualifies_next = qual;
            end
            nsst_pkg::CMD_READ:
            begin
                entry_value_next = read_value;
            end
            nsst_pkg::CMD_CLEAR:
            begin
                placed_rank_next = '0;
            end
            default:
            begin
                placed_rank_next = '0;
            end
        endcase
    end

    // Register the done strobe from the accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            placed_rank_reg <= placed_rank_next;
            qualifies_reg   <= qualifies_next;
            entry_value_reg <= entry_value_next;
        end
    end

    assign done        = done_reg;
    assign placed_rank = placed_rank_reg;
    assign qualifies   = qualifies_reg;
    assign entry_value = entry_value_reg;

endmodule
